// File: rtl/rlp_pkg.sv
// Package with the beat types and the byte role, error and phase codes of the RLP parser.
`timescale 1ns / 1ps

package rlp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  byte_role;
    logic [4:0]  nest_level;
    logic [6:0]  element_index;
    logic [31:0] item_length;
    logic        item_done;
    logic [4:0]  lists_closed;
    logic [2:0]  error_code;
  } out_beat_t;

  localparam logic [2:0] ROLE_SINGLE      = 3'd0;
  localparam logic [2:0] ROLE_STR_PREFIX  = 3'd1;
  localparam logic [2:0] ROLE_STR_LEN     = 3'd2;
  localparam logic [2:0] ROLE_CONTENT     = 3'd3;
  localparam logic [2:0] ROLE_LIST_PREFIX = 3'd4;
  localparam logic [2:0] ROLE_LIST_LEN    = 3'd5;
  localparam logic [2:0] ROLE_REMAINDER   = 3'd6;
  localparam logic [2:0] ROLE_DISCARDED   = 3'd7;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TRUNCATED = 3'd1;
  localparam logic [2:0] ERR_OVERRUN   = 3'd2;
  localparam logic [2:0] ERR_CAPACITY  = 3'd3;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd4;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd5;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_CONTENT = 3'd2;
  localparam logic [2:0] PH_REMAIN  = 3'd3;
  localparam logic [2:0] PH_ERROR   = 3'd4;

  localparam logic [7:0] SINGLE_MAX     = 8'h7f;
  localparam logic [7:0] SHORT_STR_MAX  = 8'hb7;
  localparam logic [7:0] LONG_STR_MAX   = 8'hbf;
  localparam logic [7:0] SHORT_LIST_MAX = 8'hf7;
  localparam logic [7:0] STR_BASE       = 8'h80;
  localparam logic [7:0] LIST_BASE      = 8'hc0;

  localparam logic [6:0] MAX_ELEMENTS_RESET = 7'd100;

endpackage

// File: rtl/rlp_stream_parser.sv
// Top level of the RLP stream parser: tags every byte of a frame with its role and position.
`timescale 1ns / 1ps

// The parser takes one byte of an RLP frame per beat and returns one registered tagged beat
// for it in the cycle after it is accepted, so a stream runs at one byte per clock whenever
// the output side keeps taking beats. All decoding for a byte is done in the cycle it is
// accepted, against the open-list stack held in flip-flops; lists that close together at one
// byte are all popped in that cycle. An error sticks until the beat marked frame_end, which
// also returns the parser to its starting state. max_elements is written through cfg_wr_en
// and should only change while the parser is idle.
module rlp_stream_parser #(
  parameter int STACK_DEPTH = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rlp_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rlp_pkg::out_beat_t out_data,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int IW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SW  = OFFSET_BITS + 34;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  logic [2:0]             phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic [3:0]             left_r, left_nxt;
  logic                   plist_r, plist_nxt;
  logic [OFFSET_BITS-1:0] send_r, send_nxt;
  logic [OFFSET_BITS-1:0] ends_r [STACK_DEPTH];
  logic [6:0]             cnt_r  [STACK_DEPTH];
  logic [SPW-1:0]         sp_r, sp_nxt;
  logic [2:0]             held_r, held_nxt;
  logic [6:0]             maxel_r;
  logic                   out_valid_r;
  rlp_pkg::out_beat_t     out_r, res;

  logic                   accept;
  logic [7:0]             b;
  logic [IW-1:0]          top_idx;
  logic [6:0]             cnt_top;
  logic [OFFSET_BITS-1:0] top_end;
  logic [31:0]            acc_new;
  logic [31:0]            n_sel;
  logic [SW-1:0]          sum;
  logic [2:0]             chk_err;
  logic [SPW-1:0]         closed;
  logic [SW-1:0]          off_plus1;
  logic                   inc;
  logic                   push;
  logic [6:0]             cnt_eff;
  logic [2:0]             err;
  logic [3:0]             left_dec;
  logic                   do_finish;
  logic                   do_payload;
  logic                   pl_list;
  logic [31:0]            pl_n;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign b         = in_data.data_byte;
  assign top_idx   = IW'(sp_r - SPW'(1));
  assign cnt_top   = (sp_r != '0) ? cnt_r[top_idx] : 7'd0;
  assign top_end   = ends_r[top_idx];
  assign acc_new   = {acc_r[23:0], b};
  assign off_plus1 = SW'(off_r) + SW'(1);

  always_comb begin
    if (phase_r == rlp_pkg::PH_LEN) begin
      n_sel = acc_new;
    end else if (b <= rlp_pkg::SHORT_STR_MAX) begin
      n_sel = 32'(b) - 32'(rlp_pkg::STR_BASE);
    end else if (b <= rlp_pkg::LONG_STR_MAX) begin
      n_sel = 32'(b) - 32'(rlp_pkg::SHORT_STR_MAX);
    end else if (b <= rlp_pkg::SHORT_LIST_MAX) begin
      n_sel = 32'(b) - 32'(rlp_pkg::LIST_BASE);
    end else begin
      n_sel = 32'(b) - 32'(rlp_pkg::SHORT_LIST_MAX);
    end
  end

  always_comb begin
    sum = SW'(off_r) + SW'(n_sel) + SW'(1);
    if (sum > SW'(OFF_MAX)) begin
      chk_err = rlp_pkg::ERR_TOO_LARGE;
    end else if (sp_r != '0 && sum > SW'(top_end)) begin
      chk_err = rlp_pkg::ERR_OVERRUN;
    end else begin
      chk_err = rlp_pkg::ERR_NONE;
    end
  end

  // Every open list encloses the current byte, so the lists ending here form the top run.
  always_comb begin
    closed = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (SPW'(i) < sp_r && SW'(ends_r[i]) == off_plus1) begin
        closed = closed + SPW'(1);
      end
    end
  end

  always_comb begin
    res        = '0;
    res.byte_out = b;
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    left_nxt   = left_r;
    plist_nxt  = plist_r;
    send_nxt   = send_r;
    sp_nxt     = sp_r;
    held_nxt   = held_r;
    inc        = 1'b0;
    push       = 1'b0;
    err        = rlp_pkg::ERR_NONE;
    left_dec   = (left_r == 4'd0) ? 4'd0 : left_r - 4'd1;
    do_finish  = 1'b0;
    do_payload = 1'b0;
    pl_list    = 1'b0;
    pl_n       = n_sel;
    cnt_eff    = cnt_top;

    if (phase_r == rlp_pkg::PH_ERROR) begin
      res.byte_role  = rlp_pkg::ROLE_DISCARDED;
      res.error_code = held_r;
    end else if (phase_r == rlp_pkg::PH_REMAIN) begin
      res.byte_role = rlp_pkg::ROLE_REMAINDER;
    end else begin
      res.nest_level = 5'(sp_r);
      if (phase_r == rlp_pkg::PH_HEADER && sp_r != '0) begin
        if (cnt_top >= maxel_r) begin
          err = rlp_pkg::ERR_CAPACITY;
        end else begin
          inc = 1'b1;
        end
      end
      cnt_eff = cnt_top + 7'(inc);
      res.element_index = (cnt_eff != 7'd0) ? cnt_eff - 7'd1 : 7'd0;

      if (phase_r == rlp_pkg::PH_HEADER) begin
        if (b <= rlp_pkg::SINGLE_MAX) begin
          res.byte_role   = rlp_pkg::ROLE_SINGLE;
          res.item_length = 32'd1;
          do_finish       = (err == rlp_pkg::ERR_NONE);
        end else if (b <= rlp_pkg::SHORT_STR_MAX) begin
          res.byte_role   = rlp_pkg::ROLE_STR_PREFIX;
          res.item_length = n_sel;
          do_payload      = (err == rlp_pkg::ERR_NONE);
        end else if (b <= rlp_pkg::LONG_STR_MAX) begin
          res.byte_role = rlp_pkg::ROLE_STR_PREFIX;
          if (err == rlp_pkg::ERR_NONE) begin
            err = chk_err;
            if (chk_err == rlp_pkg::ERR_NONE) begin
              left_nxt  = 4'(n_sel);
              acc_nxt   = 32'd0;
              plist_nxt = 1'b0;
              phase_nxt = rlp_pkg::PH_LEN;
            end
          end
        end else if (b <= rlp_pkg::SHORT_LIST_MAX) begin
          res.byte_role   = rlp_pkg::ROLE_LIST_PREFIX;
          res.item_length = n_sel;
          do_payload      = (err == rlp_pkg::ERR_NONE);
          pl_list         = 1'b1;
        end else begin
          res.byte_role = rlp_pkg::ROLE_LIST_PREFIX;
          if (err == rlp_pkg::ERR_NONE) begin
            err = chk_err;
            if (chk_err == rlp_pkg::ERR_NONE) begin
              left_nxt  = 4'(n_sel);
              acc_nxt   = 32'd0;
              plist_nxt = 1'b1;
              phase_nxt = rlp_pkg::PH_LEN;
            end
          end
        end
      end else if (phase_r == rlp_pkg::PH_LEN) begin
        res.byte_role = plist_r ? rlp_pkg::ROLE_LIST_LEN : rlp_pkg::ROLE_STR_LEN;
        if (acc_r[31:24] != 8'd0) begin
          err = rlp_pkg::ERR_TOO_LARGE;
        end else begin
          acc_nxt  = acc_new;
          left_nxt = left_dec;
          if (left_dec == 4'd0) begin
            res.item_length = acc_new;
            do_payload      = 1'b1;
            pl_list         = plist_r;
          end
        end
      end else begin
        res.byte_role   = rlp_pkg::ROLE_CONTENT;
        res.item_length = acc_r;
        do_finish       = (off_plus1 == SW'(send_r));
      end

      if (do_payload) begin
        if (pl_n == 32'd0) begin
          do_finish = 1'b1;
        end else if (chk_err != rlp_pkg::ERR_NONE) begin
          err = chk_err;
        end else if (pl_list) begin
          if (sp_r >= SPW'(STACK_DEPTH)) begin
            err = rlp_pkg::ERR_TOO_DEEP;
          end else begin
            push      = 1'b1;
            sp_nxt    = sp_r + SPW'(1);
            phase_nxt = rlp_pkg::PH_HEADER;
          end
        end else begin
          acc_nxt   = pl_n;
          send_nxt  = sum[OFFSET_BITS-1:0];
          phase_nxt = rlp_pkg::PH_CONTENT;
        end
      end

      if (do_finish) begin
        res.item_done    = (phase_r != rlp_pkg::PH_LEN || pl_n == 32'd0) ? 1'b1 : 1'b0;
        res.lists_closed = 5'(closed);
        sp_nxt           = sp_r - closed;
        phase_nxt        = (sp_r == closed) ? rlp_pkg::PH_REMAIN : rlp_pkg::PH_HEADER;
      end

      if (err == rlp_pkg::ERR_NONE && in_data.frame_end && phase_nxt != rlp_pkg::PH_REMAIN) begin
        err = rlp_pkg::ERR_TRUNCATED;
      end
      if (err != rlp_pkg::ERR_NONE) begin
        res.item_length  = 32'd0;
        res.item_done    = 1'b0;
        res.lists_closed = 5'd0;
        phase_nxt        = rlp_pkg::PH_ERROR;
        held_nxt         = err;
        push             = 1'b0;
      end
      res.error_code = err;
    end

    off_nxt = (off_r == OFF_MAX) ? off_r : off_r + OFFSET_BITS'(1);

    if (in_data.frame_end) begin
      phase_nxt = rlp_pkg::PH_HEADER;
      off_nxt   = '0;
      acc_nxt   = 32'd0;
      left_nxt  = 4'd0;
      plist_nxt = 1'b0;
      send_nxt  = '0;
      sp_nxt    = '0;
      held_nxt  = rlp_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rlp_pkg::PH_HEADER;
      off_r       <= '0;
      acc_r       <= 32'd0;
      left_r      <= 4'd0;
      plist_r     <= 1'b0;
      send_r      <= '0;
      sp_r        <= '0;
      held_r      <= rlp_pkg::ERR_NONE;
      maxel_r     <= rlp_pkg::MAX_ELEMENTS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        maxel_r <= cfg_wr_data;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        off_r   <= off_nxt;
        acc_r   <= acc_nxt;
        left_r  <= left_nxt;
        plist_r <= plist_nxt;
        send_r  <= send_nxt;
        sp_r    <= sp_nxt;
        held_r  <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
      if (inc) begin
        cnt_r[top_idx] <= cnt_eff;
      end
      if (push) begin
        ends_r[IW'(sp_r)] <= sum[OFFSET_BITS-1:0];
        cnt_r[IW'(sp_r)]  <= 7'd0;
      end
    end
  end

endmodule

// File: tb/rlp_stream_parser_tb.sv
// Self-checking testbench for the RLP stream parser, with byte-level tag prediction.
`timescale 1ns / 1ps

module rlp_stream_parser_tb;
  import rlp_pkg::*;

  typedef logic [7:0] bytes_t[$];

  localparam longint unsigned OFF_MAX = 64'hffff_ffff;
  localparam int DEPTH = 16;
  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = '0;

  in_beat_t pending_beats[$];
  out_beat_t expected_tags[$];
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int cycle = 0;
  int max_elems = MAX_ELEMENTS_RESET;

  logic [2:0] phase;
  longint unsigned offset, accum, str_end;
  int len_left;
  bit pend_list;
  longint unsigned list_end[DEPTH];
  int elem_count[DEPTH];
  int depth_ptr;
  logic [2:0] held_err;

  rlp_stream_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void clear_frame();
    phase = PH_HEADER;
    offset = 0;
    accum = 0;
    str_end = 0;
    len_left = 0;
    pend_list = 0;
    depth_ptr = 0;
    held_err = ERR_NONE;
    for (int i = 0; i < DEPTH; i++) begin
      list_end[i] = 0;
      elem_count[i] = 0;
    end
  endfunction

  function automatic logic [2:0] span_error(longint unsigned o, longint unsigned n);
    if (n + 1 > OFF_MAX - o) return ERR_TOO_LARGE;
    if (depth_ptr > 0 && o + 1 + n > list_end[depth_ptr-1]) return ERR_OVERRUN;
    return ERR_NONE;
  endfunction

  function automatic int close_lists(longint unsigned o);
    int n;
    n = 0;
    while (depth_ptr > 0 && list_end[depth_ptr-1] == o + 1) begin
      depth_ptr--;
      n++;
    end
    phase = (depth_ptr == 0) ? PH_REMAIN : PH_HEADER;
    return n;
  endfunction

  function automatic logic [2:0] open_payload(longint unsigned o, longint unsigned n,
                                              bit is_list, inout bit done, inout int closed);
    logic [2:0] e;
    if (n == 0) begin
      done = 1;
      closed = close_lists(o);
      return ERR_NONE;
    end
    e = span_error(o, n);
    if (e != ERR_NONE) return e;
    if (is_list) begin
      if (depth_ptr >= DEPTH) return ERR_TOO_DEEP;
      list_end[depth_ptr] = o + 1 + n;
      elem_count[depth_ptr] = 0;
      depth_ptr++;
      phase = PH_HEADER;
    end else begin
      accum = n;
      str_end = o + 1 + n;
      phase = PH_CONTENT;
    end
    return ERR_NONE;
  endfunction

  function automatic out_beat_t tag_byte(in_beat_t ib);
    out_beat_t r;
    logic [7:0] b;
    longint unsigned o, len;
    bit done;
    int closed, nest, idx;
    logic [2:0] role, err;
    b = ib.data_byte;
    o = offset;
    len = 0;
    done = 0;
    closed = 0;
    nest = 0;
    idx = 0;
    role = ROLE_SINGLE;
    err = ERR_NONE;
    if (phase == PH_ERROR) begin
      role = ROLE_DISCARDED;
      err = held_err;
    end else if (phase == PH_REMAIN) begin
      role = ROLE_REMAINDER;
    end else begin
      nest = depth_ptr;
      if (phase == PH_HEADER && depth_ptr > 0) begin
        if (elem_count[depth_ptr-1] >= max_elems) err = ERR_CAPACITY;
        else elem_count[depth_ptr-1]++;
      end
      if (depth_ptr > 0 && elem_count[depth_ptr-1] > 0) idx = elem_count[depth_ptr-1] - 1;
      if (phase == PH_HEADER) begin
        if (b <= SINGLE_MAX) begin
          role = ROLE_SINGLE;
          len = 1;
          if (err == ERR_NONE) begin
            done = 1;
            closed = close_lists(o);
          end
        end else if (b <= SHORT_STR_MAX) begin
          role = ROLE_STR_PREFIX;
          len = b - STR_BASE;
          if (err == ERR_NONE) err = open_payload(o, len, 0, done, closed);
        end else if (b <= LONG_STR_MAX) begin
          role = ROLE_STR_PREFIX;
          if (err == ERR_NONE) err = span_error(o, b - SHORT_STR_MAX);
          if (err == ERR_NONE) begin
            len_left = b - SHORT_STR_MAX;
            accum = 0;
            pend_list = 0;
            phase = PH_LEN;
          end
        end else if (b <= SHORT_LIST_MAX) begin
          role = ROLE_LIST_PREFIX;
          len = b - LIST_BASE;
          if (err == ERR_NONE) err = open_payload(o, len, 1, done, closed);
        end else begin
          role = ROLE_LIST_PREFIX;
          if (err == ERR_NONE) err = span_error(o, b - SHORT_LIST_MAX);
          if (err == ERR_NONE) begin
            len_left = b - SHORT_LIST_MAX;
            accum = 0;
            pend_list = 1;
            phase = PH_LEN;
          end
        end
      end else if (phase == PH_LEN) begin
        role = pend_list ? ROLE_LIST_LEN : ROLE_STR_LEN;
        if ((accum >> 24) != 0) begin
          err = ERR_TOO_LARGE;
        end else begin
          accum = ((accum << 8) | b) & OFF_MAX;
          if (len_left > 0) len_left--;
          if (len_left == 0) begin
            len = accum;
            err = open_payload(o, len, pend_list, done, closed);
          end
        end
      end else begin
        role = ROLE_CONTENT;
        len = accum;
        if (o + 1 == str_end) begin
          done = 1;
          closed = close_lists(o);
        end
      end
      if (err == ERR_NONE && ib.frame_end && phase != PH_REMAIN) err = ERR_TRUNCATED;
      if (err != ERR_NONE) begin
        len = 0;
        done = 0;
        closed = 0;
        held_err = err;
        phase = PH_ERROR;
      end
    end
    if (offset < OFF_MAX) offset++;
    r.byte_out = b;
    r.byte_role = role;
    r.nest_level = nest[4:0];
    r.element_index = idx[6:0];
    r.item_length = len[31:0];
    r.item_done = done;
    r.lists_closed = closed[4:0];
    r.error_code = err;
    if (ib.frame_end) clear_frame();
    return r;
  endfunction

  // Builds one item, well-formed unless a list body exceeds 255 bytes, recursing into lists while lvl is below 4.
  function automatic bytes_t make_item(int lvl);
    bytes_t q, body, kid;
    int sel, n;
    sel = $urandom_range(0, 9);
    if (sel <= 2) begin
      q.push_back(8'($urandom_range(0, 127)));
    end else if (sel <= 4) begin
      n = $urandom_range(0, 10);
      q.push_back(8'(STR_BASE + n));
      repeat (n) q.push_back(8'($urandom));
    end else if (sel == 5) begin
      n = $urandom_range(56, 70);
      if ($urandom_range(0, 1)) begin
        q = {8'hb9, 8'h00, 8'(n)};
      end else begin
        q = {8'hb8, 8'(n)};
      end
      repeat (n) q.push_back(8'($urandom));
    end else begin
      n = (lvl < 4) ? $urandom_range(0, 4) : 0;
      repeat (n) begin
        kid = make_item(lvl + 1);
        body = {body, kid};
      end
      if (body.size() > 55 || $urandom_range(0, 7) == 0) begin
        q = {8'hf8, 8'(body.size())};
      end else begin
        q.push_back(8'(LIST_BASE + body.size()));
      end
      q = {q, body};
    end
    return q;
  endfunction

  function automatic int queue_frame(bytes_t f);
    in_beat_t ib;
    foreach (f[i]) begin
      ib.data_byte = f[i];
      ib.frame_end = (i == f.size() - 1);
      pending_beats.push_back(ib);
    end
    return f.size();
  endfunction

  function automatic bytes_t wide_list(int w);
    bytes_t q;
    q = (w > 55) ? {8'hf8, 8'(w)} : {8'(LIST_BASE + w)};
    repeat (w) q.push_back(8'($urandom_range(0, 127)));
    return q;
  endfunction

  function automatic bytes_t random_frame();
    bytes_t f;
    int sel, cut;
    sel = $urandom_range(0, 99);
    f = make_item(0);
    if (sel < 65) begin
    end else if (sel < 75) begin
      repeat ($urandom_range(1, 3)) f.push_back(8'($urandom));
    end else if (sel < 85) begin
      cut = $urandom_range(1, f.size());
      f = f[0:cut-1];
    end else if (sel < 91) begin
      f.delete();
      repeat ($urandom_range(1, 6)) f.push_back(8'($urandom));
    end else if (sel < 95) begin
      f.delete();
      for (int k = 17; k >= 1; k--) f.push_back(8'(LIST_BASE + k));
      f.push_back(8'h00);
    end else if (sel < 97) begin
      f = {8'hbb, 8'hff, 8'hff, 8'hff, 8'hff};
    end else begin
      f = {8'hbf, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    end
    return f;
  endfunction

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_tags.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_elems(int v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 7'(v);
    max_elems = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_tags.push_back(tag_byte(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          in_data <= pending_beats.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    cycle++;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data);
      end else begin
        want = expected_tags.pop_front();
        if (out_data.byte_out !== want.byte_out || out_data.byte_role !== want.byte_role ||
            out_data.nest_level !== want.nest_level ||
            out_data.element_index !== want.element_index ||
            out_data.item_length !== want.item_length ||
            out_data.item_done !== want.item_done ||
            out_data.lists_closed !== want.lists_closed ||
            out_data.error_code !== want.error_code) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
    case ((cycle >> 8) & 3)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ((cycle & 7) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_beats.size() == 0 && !in_valid && expected_tags.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("rlp_stream_parser_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int settings[5];
    int sent;
    clear_frame();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_max_elems(MAX_ELEMENTS_RESET);
    void'(queue_frame({8'h00}));
    void'(queue_frame({8'h7f}));
    void'(queue_frame({8'h80}));
    void'(queue_frame({8'hc0}));
    void'(queue_frame({8'h81, 8'hff}));
    void'(queue_frame({8'hc2, 8'h01, 8'h02}));
    void'(queue_frame({8'h00, 8'h55}));
    void'(queue_frame({8'h82, 8'h01}));
    void'(queue_frame({8'hc1, 8'h82, 8'h01, 8'h02}));
    void'(queue_frame({8'hbb, 8'hff, 8'hff, 8'hff, 8'hff}));
    void'(queue_frame({8'hb8, 8'h00}));
    void'(queue_frame({8'hf8, 8'h00}));
    wait_idle();
    settings = '{1, 127, $urandom_range(2, 126), 2, 100};
    foreach (settings[p]) begin
      write_max_elems(settings[p]);
      sent = queue_frame(wide_list(settings[p] + 1));
      while (sent < 130) sent += queue_frame(random_frame());
      wait_idle();
    end
    if (mismatches == 0) begin
      $display("rlp_stream_parser_tb: done, clean");
    end else begin
      $display("rlp_stream_parser_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rlp_pkg.sv
rtl/rlp_stream_parser.sv
tb/rlp_stream_parser_tb.sv
